/* rtl/core/cda_pkg.sv */
package cda_pkg;

   // Field widths of the request and result items
   localparam int YEAR_WIDTH   = 12;
   localparam int AMOUNT_WIDTH = 12;
   localparam int CFG_WIDTH    = 12;
   localparam int DAY_WIDTH    = 5;
   localparam int MONTH_WIDTH  = 4;

   // Working year: signed, wide enough for year +/- amount without wrap
   localparam int WYEAR_WIDTH = ((YEAR_WIDTH > AMOUNT_WIDTH) ? YEAR_WIDTH : AMOUNT_WIDTH) + 2;

   // Amount compared against a day count
   localparam int CMP_WIDTH = AMOUNT_WIDTH + DAY_WIDTH;

   // Shared multiplier operand width
   localparam int MUL_WIDTH = 16;

   // Divisibility by 25: y * inverse (mod 2^16) is at most the limit
   localparam logic [MUL_WIDTH-1:0] INV25       = 16'd23593;
   localparam logic [MUL_WIDTH-1:0] INV25_LIMIT = 16'd2621;

   // Division by 3 of a value below 2^16: (x * 43691) >> 17
   localparam logic [MUL_WIDTH-1:0] DIV3_MUL   = 16'd43691;
   localparam int                   DIV3_SHIFT = 17;

   localparam logic [MONTH_WIDTH-1:0] MONTHS    = 4'd12;
   localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd2;
   localparam logic [DAY_WIDTH-1:0]   FEB_LEAP_LEN = 5'd29;

   localparam logic [DAY_WIDTH-1:0] MONTH_LEN [0:12] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Reset values
   localparam logic [DAY_WIDTH-1:0]   RESET_DAY   = 5'd1;
   localparam logic [MONTH_WIDTH-1:0] RESET_MONTH = 4'd1;
   localparam logic [YEAR_WIDTH-1:0]  RESET_YEAR  = YEAR_WIDTH'(2001);
   localparam logic [CFG_WIDTH-1:0]   RESET_MIN_YEAR = CFG_WIDTH'(1500);
   localparam logic [CFG_WIDTH-1:0]   RESET_MAX_YEAR = CFG_WIDTH'(3000);

   // Register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_YEAR = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_YEAR = 1'b1;

   typedef enum logic [2:0] {
      OP_SET        = 3'd0,
      OP_ADD_DAYS   = 3'd1,
      OP_SUB_DAYS   = 3'd2,
      OP_ADD_MONTHS = 3'd3,
      OP_SUB_MONTHS = 3'd4,
      OP_ADD_YEARS  = 3'd5,
      OP_SUB_YEARS  = 3'd6
   } req_op_type;

   typedef struct packed {
      req_op_type                req_type;
      logic [AMOUNT_WIDTH-1:0]   amount;
      logic [DAY_WIDTH-1:0]      set_day;
      logic [MONTH_WIDTH-1:0]    set_month;
      logic [YEAR_WIDTH-1:0]     set_year;
   } req_item_type;

   typedef struct packed {
      logic [DAY_WIDTH-1:0]      cur_day;
      logic [MONTH_WIDTH-1:0]    cur_month;
      logic [YEAR_WIDTH-1:0]     cur_year;
      logic                      error;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEARS,
      ST_MDIV,
      ST_MQUOT,
      ST_MAPPLY,
      ST_LEAP_MUL,
      ST_LEAP_SET,
      ST_DAYS,
      ST_FILL,
      ST_CHECK,
      ST_DONE
   } cda_state_type;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic load;
      logic year_step;
      logic mdiv;
      logic mquot;
      logic mapply;
      logic leap_mul;
      logic leap_set;
      logic day_step;
      logic fill;
      logic check;
      logic out_load;
   } cda_ctrl_type;

   // Datapath status back to the sequencer
   typedef struct packed {
      req_op_type op;
      logic       day_fits;
      logic       year_cross;
      logic       fill_pend;
   } cda_stat_type;

   // Length of a month; zero for a month code outside 1..12
   function automatic logic [DAY_WIDTH-1:0] days_in_month(
      input logic [MONTH_WIDTH-1:0] month,
      input logic                   leap
   );
      logic [DAY_WIDTH-1:0] len;
      if (month > MONTHS) begin
         len = '0;
      end else if (month == MONTH_FEB && leap) begin
         len = FEB_LEAP_LEN;
      end else begin
         len = MONTH_LEN[month];
      end
      return len;
   endfunction

endpackage

/* rtl/core/cda_ctrl.sv */
module cda_ctrl
   import cda_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_op_type   req_op,
   input  cda_stat_type stat,
   input  logic         out_free,
   output cda_ctrl_type ctrl,
   output logic         busy
);

   cda_state_type state_ff;
   cda_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_SET, OP_ADD_DAYS, OP_SUB_DAYS: state_in = ST_LEAP_MUL;
                  OP_ADD_MONTHS, OP_SUB_MONTHS:     state_in = ST_MDIV;
                  OP_ADD_YEARS, OP_SUB_YEARS:       state_in = ST_YEARS;
                  default:                          state_in = ST_DONE;
               endcase
            end
         end
         ST_YEARS:    state_in = ST_LEAP_MUL;
         ST_MDIV:     state_in = ST_MQUOT;
         ST_MQUOT:    state_in = ST_MAPPLY;
         ST_MAPPLY:   state_in = ST_LEAP_MUL;
         ST_LEAP_MUL: state_in = ST_LEAP_SET;
         ST_LEAP_SET: begin
            if (stat.op == OP_ADD_DAYS || stat.op == OP_SUB_DAYS) begin
               state_in = stat.fill_pend ? ST_FILL : ST_DAYS;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_FILL:     state_in = ST_DAYS;
         ST_DAYS: begin
            priority if (stat.day_fits) begin
               state_in = ST_CHECK;
            end else if (stat.year_cross) begin
               state_in = ST_LEAP_MUL;
            end else begin
               state_in = ST_DAYS;
            end
         end
         ST_CHECK:    state_in = ST_DONE;
         ST_DONE:     state_in = out_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      ctrl           = '0;
      ctrl.load      = (state_ff == ST_IDLE) && req_valid;
      ctrl.year_step = (state_ff == ST_YEARS);
      ctrl.mdiv      = (state_ff == ST_MDIV);
      ctrl.mquot     = (state_ff == ST_MQUOT);
      ctrl.mapply    = (state_ff == ST_MAPPLY);
      ctrl.leap_mul  = (state_ff == ST_LEAP_MUL);
      ctrl.leap_set  = (state_ff == ST_LEAP_SET);
      ctrl.day_step  = (state_ff == ST_DAYS);
      ctrl.fill      = (state_ff == ST_FILL);
      ctrl.check     = (state_ff == ST_CHECK);
      ctrl.out_load  = (state_ff == ST_DONE) && out_free;
      busy           = (state_ff != ST_IDLE);
   end

endmodule

/* rtl/core/cda_dpath.sv */
module cda_dpath
   import cda_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cda_ctrl_type         ctrl,
   input  req_item_type         req,
   input  logic [CFG_WIDTH-1:0] min_year,
   input  logic [CFG_WIDTH-1:0] max_year,
   output cda_stat_type         stat,
   output rsp_item_type         result
);

   localparam int EXT_W = WYEAR_WIDTH - YEAR_WIDTH;
   localparam int CFG_EXT_W = WYEAR_WIDTH - CFG_WIDTH;
   localparam logic signed [WYEAR_WIDTH-1:0] YEAR_TOP = {{EXT_W{1'b0}}, {YEAR_WIDTH{1'b1}}};

   // Held date
   logic [DAY_WIDTH-1:0]   day_ff,   day_in;
   logic [MONTH_WIDTH-1:0] month_ff, month_in;
   logic [YEAR_WIDTH-1:0]  year_ff,  year_in;
   logic                   err_ff,   err_in;
   logic                   fill_ff,  fill_in;

   // Working date and operands
   req_op_type                     op_ff,   op_in;
   logic [DAY_WIDTH-1:0]           wd_ff,   wd_in;
   logic [MONTH_WIDTH-1:0]         wm_ff,   wm_in;
   logic signed [WYEAR_WIDTH-1:0]  wy_ff,   wy_in;
   logic [AMOUNT_WIDTH-1:0]        n_ff,    n_in;
   logic [AMOUNT_WIDTH-1:0]        q_ff,    q_in;
   logic [2*MUL_WIDTH-1:0]         prod_ff, prod_in;
   logic                           leap_ff, leap_in;

   logic [DAY_WIDTH-1:0]           len;
   logic [DAY_WIDTH-1:0]           room;
   logic                           is_add;
   logic                           day_fits;
   logic [MUL_WIDTH-1:0]           mul_a;
   logic [MUL_WIDTH-1:0]           mul_b;
   logic signed [WYEAR_WIDTH-1:0]  n_s;
   logic signed [WYEAR_WIDTH-1:0]  q_s;
   logic [DAY_WIDTH-1:0]           mm1;
   logic [DAY_WIDTH-1:0]           msum;
   logic [DAY_WIDTH-1:0]           mrem;
   logic                           mcarry;
   logic                           year_ok;
   logic                           chk_err;
   logic [DAY_WIDTH-1:0]           clamp_d;

   // Shared multiplier: leap test of the working year, or amount / 12
   always_comb begin
      mul_a = ctrl.mdiv ? MUL_WIDTH'(n_ff >> 2) : MUL_WIDTH'(wy_ff);
      mul_b = ctrl.mdiv ? DIV3_MUL : INV25;
   end

   // Day stepping status
   always_comb begin
      len      = days_in_month(wm_ff, leap_ff);
      room     = len - wd_ff;
      is_add   = (op_ff == OP_ADD_DAYS);
      day_fits = is_add ? (CMP_WIDTH'(n_ff) <= CMP_WIDTH'(room))
                        : (CMP_WIDTH'(n_ff) <  CMP_WIDTH'(wd_ff));
      stat.op         = op_ff;
      stat.day_fits   = day_fits;
      stat.year_cross = is_add ? (wm_ff == MONTHS) : (wm_ff == 4'd1);
      stat.fill_pend  = fill_ff;
   end

   // Month arithmetic terms
   always_comb begin
      n_s  = $signed({{(WYEAR_WIDTH-AMOUNT_WIDTH){1'b0}}, n_ff});
      q_s  = $signed({{(WYEAR_WIDTH-AMOUNT_WIDTH){1'b0}}, q_ff});
      mm1  = DAY_WIDTH'(wm_ff) - 5'd1;
      mrem = DAY_WIDTH'(n_ff[MONTH_WIDTH-1:0]);
      if (op_ff == OP_ADD_MONTHS) begin
         msum   = mm1 + mrem;
         mcarry = (msum >= DAY_WIDTH'(MONTHS));
         if (mcarry) begin
            msum = msum - DAY_WIDTH'(MONTHS);
         end
      end else begin
         mcarry = (mm1 < mrem);
         msum   = mcarry ? (mm1 + DAY_WIDTH'(MONTHS) - mrem) : (mm1 - mrem);
      end
   end

   // Final check of the working date
   always_comb begin
      year_ok = (wy_ff >= $signed({{CFG_EXT_W{1'b0}}, min_year})) &&
                (wy_ff <= $signed({{CFG_EXT_W{1'b0}}, max_year})) &&
                (wy_ff >= 0) && (wy_ff <= YEAR_TOP);
      clamp_d = (wd_ff > len) ? len : wd_ff;
      if (op_ff == OP_SET) begin
         chk_err = (wd_ff == '0) || (wd_ff > len) || !year_ok;
      end else begin
         chk_err = !year_ok;
      end
   end

   // Next values
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      err_in   = err_ff;
      fill_in  = fill_ff;
      op_in    = op_ff;
      wd_in    = wd_ff;
      wm_in    = wm_ff;
      wy_in    = wy_ff;
      n_in     = n_ff;
      q_in     = q_ff;
      prod_in  = prod_ff;
      leap_in  = leap_ff;

      // take a new item
      if (ctrl.load) begin
         op_in   = req.req_type;
         n_in    = req.amount;
         fill_in = 1'b0;
         if (req.req_type == OP_SET) begin
            wd_in = req.set_day;
            wm_in = req.set_month;
            wy_in = $signed({{EXT_W{1'b0}}, req.set_year});
         end else begin
            wd_in = day_ff;
            wm_in = month_ff;
            wy_in = $signed({{EXT_W{1'b0}}, year_ff});
         end
         unique case (req.req_type)
            OP_SET, OP_ADD_DAYS, OP_SUB_DAYS, OP_ADD_MONTHS,
            OP_SUB_MONTHS, OP_ADD_YEARS, OP_SUB_YEARS: err_in = 1'b0;
            default:                                   err_in = 1'b1;
         endcase
      end

      // whole years
      if (ctrl.year_step) begin
         wy_in = (op_ff == OP_ADD_YEARS) ? (wy_ff + n_s) : (wy_ff - n_s);
      end

      // multiplier
      if (ctrl.mdiv || ctrl.leap_mul) begin
         prod_in = mul_a * mul_b;
      end

      // months: quotient and remainder of amount / 12
      if (ctrl.mquot) begin
         q_in = AMOUNT_WIDTH'(prod_ff >> DIV3_SHIFT);
         n_in = n_ff - ((q_in << 3) + (q_in << 2));
      end

      if (ctrl.mapply) begin
         wm_in = MONTH_WIDTH'(msum + 5'd1);
         if (op_ff == OP_ADD_MONTHS) begin
            wy_in = wy_ff + q_s + WYEAR_WIDTH'(mcarry);
         end else begin
            wy_in = wy_ff - q_s - WYEAR_WIDTH'(mcarry);
         end
      end

      // leap: divisible by 4, and by 400 when divisible by 100
      if (ctrl.leap_set) begin
         leap_in = (wy_ff[1:0] == 2'b00) &&
                   ((prod_ff[MUL_WIDTH-1:0] > INV25_LIMIT) || (wy_ff[3:0] == 4'b0000));
      end

      // one day or month step
      if (ctrl.day_step) begin
         if (day_fits) begin
            wd_in = is_add ? (wd_ff + DAY_WIDTH'(n_ff)) : (wd_ff - DAY_WIDTH'(n_ff));
            n_in  = '0;
         end else if (is_add) begin
            n_in  = n_ff - AMOUNT_WIDTH'(room) - AMOUNT_WIDTH'(1);
            wd_in = 5'd1;
            if (wm_ff == MONTHS) begin
               wm_in = 4'd1;
               wy_in = wy_ff + WYEAR_WIDTH'(1);
            end else begin
               wm_in = wm_ff + MONTH_WIDTH'(1);
            end
         end else begin
            n_in = n_ff - AMOUNT_WIDTH'(wd_ff);
            if (wm_ff == 4'd1) begin
               wm_in   = MONTHS;
               wy_in   = wy_ff - WYEAR_WIDTH'(1);
               fill_in = 1'b1;
            end else begin
               wm_in = wm_ff - MONTH_WIDTH'(1);
               wd_in = days_in_month(wm_ff - MONTH_WIDTH'(1), leap_ff);
            end
         end
      end

      // last day of the month entered across a year boundary
      if (ctrl.fill) begin
         wd_in   = len;
         fill_in = 1'b0;
      end

      // commit or reject
      if (ctrl.check) begin
         err_in = chk_err;
         if (!chk_err) begin
            day_in   = clamp_d;
            month_in = wm_ff;
            year_in  = wy_ff[YEAR_WIDTH-1:0];
         end
      end
   end

   // Control and held date
   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= RESET_DAY;
         month_ff <= RESET_MONTH;
         year_ff  <= RESET_YEAR;
         err_ff   <= 1'b0;
         fill_ff  <= 1'b0;
      end else begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         err_ff   <= err_in;
         fill_ff  <= fill_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      wd_ff   <= wd_in;
      wm_ff   <= wm_in;
      wy_ff   <= wy_in;
      n_ff    <= n_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
      leap_ff <= leap_in;
   end

   always_comb begin
      result.cur_day   = day_ff;
      result.cur_month = month_ff;
      result.cur_year  = year_ff;
      result.error     = err_ff;
   end

endmodule

/* rtl/core/calendar_date_adjust.sv */
// Channel | Ports                            | Direction | Moves
// --------+----------------------------------+-----------+---------------------------
// request | req_valid, req_stall, req_data   | in        | one request item
// result  | rsp_valid, rsp_stall, rsp_data   | out       | held date and error flag
// config  | csr_wr_en, csr_index, csr_wr_data| in        | min_year / max_year write
//
// One item at a time; req_stall is high from acceptance until the result is in the
// output register. Set goes LEAP_MUL, LEAP_SET, CHECK, DONE; years put YEARS first,
// months MDIV, MQUOT, MAPPLY. Days add a DAYS state per month crossed and redo the
// leap test per year crossed (plus FILL backwards) on the shared 16x16 multiplier.
// Synchronous reset gives 1/1/2001 and a window of 1500..3000; no clearing pass.
// The output register frees the sequencer while a result waits under rsp_stall.
module calendar_date_adjust
   import cda_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_item_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_item_type               rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wr_data
);

   logic [CFG_WIDTH-1:0] min_year_ff, min_year_in;
   logic [CFG_WIDTH-1:0] max_year_ff, max_year_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;

   cda_ctrl_type ctrl;
   cda_stat_type stat;
   rsp_item_type result;
   logic         busy;
   logic         out_free;

   // Output register is free when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.req_type),
      .stat      (stat),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .busy      (busy)
   );

   cda_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req      (req_data),
      .min_year (min_year_ff),
      .max_year (max_year_ff),
      .stat     (stat),
      .result   (result)
   );

   // Year window registers
   always_comb begin
      min_year_in = min_year_ff;
      max_year_in = max_year_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_YEAR: min_year_in = csr_wr_data;
            CSR_MAX_YEAR: max_year_in = csr_wr_data;
            default:      min_year_in = min_year_ff;
         endcase
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff  <= RESET_MIN_YEAR;
         max_year_ff  <= RESET_MAX_YEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_year_ff  <= min_year_in;
         max_year_ff  <= max_year_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
